@@ src/svm_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// svm_pkg: shared types and constants of the stack machine
// Opcodes, status codes, request kinds, register indexes and memory geometry.
// ============================================================================
package svm_pkg;

    // Memory geometry
    localparam int MEM_WORDS = 16384;
    localparam int IDX_W     = $clog2(MEM_WORDS);

    // Request kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_EXEC  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EXIT   = 3'd1;
    localparam logic [2:0] ST_BADOP  = 3'd2;
    localparam logic [2:0] ST_SYSC   = 3'd3;
    localparam logic [2:0] ST_DIVZ   = 3'd4;

    // Configuration register indexes
    localparam logic REG_START = 1'b0;
    localparam logic REG_STACK = 1'b1;

    // Opcodes
    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_CALL = 6'd3;
    localparam logic [5:0] OP_JZ   = 6'd4;
    localparam logic [5:0] OP_JNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_OPEN = 6'd30;
    localparam logic [5:0] OP_READ = 6'd31;
    localparam logic [5:0] OP_CLOS = 6'd32;
    localparam logic [5:0] OP_PRTF = 6'd33;
    localparam logic [5:0] OP_MALC = 6'd34;
    localparam logic [5:0] OP_MSET = 6'd35;
    localparam logic [5:0] OP_MCMP = 6'd36;
    localparam logic [5:0] OP_EXIT = 6'd37;
    localparam logic [5:0] OP_BAD  = 6'd63;

    // Word index of a byte address
    function automatic logic [IDX_W-1:0] mem_idx(input logic [31:0] addr);
        mem_idx = addr[IDX_W+1:2];
    endfunction

    // Sign-extend the low byte
    function automatic logic [31:0] sext8(input logic [7:0] b);
        sext8 = {{24{b[7]}}, b};
    endfunction

endpackage

@@ src/stack_vm_instruction_step.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stack_vm_instruction_step: word-oriented stack machine, one request at a time
// Sequencer over a word memory, a shared ALU and an iterative divider.
// ============================================================================
// A request is taken when start is high and busy is low; busy stays high until
// the result has been shown. The result appears for exactly one cycle with
// o_done high, and the receiver cannot stall it. Write and start requests go
// straight to S_OUT; reads pass through S_RD first. Instruction time is set by
// the single memory read port (opcode fetch, operand or stack reads in turn);
// DIV and MOD wait on the 32-step divider. No clearing pass: memory is
// undefined until written.
module stack_vm_instruction_step import svm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic [15:0]        i_address,
    input  logic signed [31:0] i_write_data,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [15:0]        o_program_counter,
    output logic signed [31:0] o_accumulator,
    output logic [16:0]        o_stack_pointer,
    output logic [16:0]        o_frame_pointer,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OP   = 7'b0000010,
        S_A    = 7'b0000100,
        S_B    = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_RD   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_start_addr;
    logic [16:0] r_stack_top;
    logic [15:0] r_pc, n_pc;
    logic [31:0] r_acc, n_acc;
    logic [16:0] r_sp, n_sp;
    logic [16:0] r_bp, n_bp;
    logic        r_halt, n_halt;
    logic [5:0]  r_op, n_op;
    logic [31:0] r_tmp, n_tmp;
    logic [2:0]  r_status, n_status;
    logic [31:0] r_res, n_res;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;
    logic [IDX_W-1:0] raddr;
    logic [31:0]      rdata;
    logic [31:0]      alu_y;
    logic             div_start;
    logic             div_done;
    logic [31:0]      div_y;
    logic [5:0]       dec_op;
    logic [16:0]      sp_dec;
    logic [31:0]      byte_sel;
    logic [31:0]      merged;
    logic             cfg_wr;

    svm_ram #(.DEPTH(MEM_WORDS), .WIDTH(32)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    svm_alu u_alu (
        .i_op (r_op),
        .i_a  (rdata),
        .i_b  (r_acc),
        .o_y  (alu_y)
    );

    svm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mod   (r_op == OP_MOD),
        .i_a     (rdata),
        .i_b     (r_acc),
        .o_done  (div_done),
        .o_y     (div_y)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_STACK) ? {15'd0, r_stack_top}
                                            : {16'd0, r_start_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr <= 16'd0;
            r_stack_top  <= 17'h10000;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_STACK) begin
                r_stack_top <= pwdata[16:0];
            end else begin
                r_start_addr <= pwdata[15:0];
            end
        end
    end

    // Opcode decode helpers
    assign dec_op = (rdata < 32'd38) ? rdata[5:0] : OP_BAD;
    assign sp_dec = r_sp - 17'd4;

    always_comb begin
        case (r_acc[1:0])
            2'd0:    byte_sel = sext8(rdata[7:0]);
            2'd1:    byte_sel = sext8(rdata[15:8]);
            2'd2:    byte_sel = sext8(rdata[23:16]);
            default: byte_sel = sext8(rdata[31:24]);
        endcase
        case (r_tmp[1:0])
            2'd0:    merged = {rdata[31:8], r_acc[7:0]};
            2'd1:    merged = {rdata[31:16], r_acc[7:0], rdata[7:0]};
            2'd2:    merged = {rdata[31:24], r_acc[7:0], rdata[15:0]};
            default: merged = {r_acc[7:0], rdata[23:0]};
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_acc     = r_acc;
        n_sp      = r_sp;
        n_bp      = r_bp;
        n_halt    = r_halt;
        n_op      = r_op;
        n_tmp     = r_tmp;
        n_status  = r_status;
        n_res     = r_res;
        we        = 1'b0;
        waddr     = mem_idx({15'd0, r_sp});
        wdata     = r_acc;
        raddr     = mem_idx({16'd0, r_pc});
        div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = ST_OK;
                    n_res    = 32'd0;
                    n_state  = S_OUT;
                    case (i_kind)
                        KIND_WRITE: begin
                            we    = 1'b1;
                            waddr = mem_idx({16'd0, i_address});
                            wdata = i_write_data;
                        end
                        KIND_READ: begin
                            raddr   = mem_idx({16'd0, i_address});
                            n_state = S_RD;
                        end
                        KIND_START: begin
                            n_pc   = r_start_addr;
                            n_sp   = r_stack_top;
                            n_bp   = r_stack_top;
                            n_acc  = 32'd0;
                            n_halt = 1'b0;
                        end
                        default: begin
                            if (r_halt) begin
                                raddr    = mem_idx({15'd0, r_sp});
                                n_status = ST_EXIT;
                                n_state  = S_RD;
                            end else begin
                                n_pc    = r_pc + 16'd4;
                                n_state = S_OP;
                            end
                        end
                    endcase
                end
            end

            // Opcode word is on rdata
            S_OP: begin
                n_op    = dec_op;
                n_state = S_A;
                case (dec_op)
                    OP_IMM, OP_LEA, OP_ENT, OP_ADJ: begin
                        n_pc = r_pc + 16'd4;
                    end
                    OP_JMP: begin
                    end
                    OP_JZ, OP_JNZ: begin
                        if ((r_acc == 32'd0) == (dec_op == OP_JNZ)) begin
                            n_pc    = r_pc + 16'd4;
                            n_state = S_OUT;
                        end
                    end
                    OP_CALL: begin
                        // push return address, then fetch target next cycle
                        we      = 1'b1;
                        waddr   = mem_idx({15'd0, sp_dec});
                        wdata   = {16'd0, r_pc + 16'd4};
                        n_sp    = sp_dec;
                        n_state = S_B;
                    end
                    OP_LEV: begin
                        raddr = mem_idx({15'd0, r_bp});
                        n_sp  = r_bp + 17'd4;
                    end
                    OP_LI, OP_LC: begin
                        raddr = mem_idx(r_acc);
                    end
                    OP_PUSH: begin
                        we      = 1'b1;
                        waddr   = mem_idx({15'd0, sp_dec});
                        n_sp    = sp_dec;
                        n_state = S_OUT;
                    end
                    OP_EXIT: begin
                        raddr    = mem_idx({15'd0, r_sp});
                        n_halt   = 1'b1;
                        n_status = ST_EXIT;
                        n_state  = S_RD;
                    end
                    OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT,
                    OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                    OP_MOD: begin
                        raddr = mem_idx({15'd0, r_sp});
                        n_sp  = r_sp + 17'd4;
                    end
                    OP_OPEN, OP_READ, OP_CLOS, OP_PRTF, OP_MALC, OP_MSET,
                    OP_MCMP: begin
                        n_status = ST_SYSC;
                        n_state  = S_OUT;
                    end
                    default: begin
                        n_status = ST_BADOP;
                        n_state  = S_OUT;
                    end
                endcase
            end

            // First data word is on rdata
            S_A: begin
                n_state = S_OUT;
                case (r_op)
                    OP_IMM: n_acc = rdata;
                    OP_LEA: n_acc = {15'd0, r_bp} + {rdata[29:0], 2'b00};
                    OP_JMP, OP_JZ, OP_JNZ: n_pc = rdata[15:0];
                    OP_ENT: begin
                        we    = 1'b1;
                        waddr = mem_idx({15'd0, sp_dec});
                        wdata = {15'd0, r_bp};
                        n_bp  = sp_dec;
                        n_sp  = sp_dec - {rdata[14:0], 2'b00};
                    end
                    OP_ADJ: n_sp = r_sp + {rdata[14:0], 2'b00};
                    OP_LEV: begin
                        n_bp    = rdata[16:0];
                        raddr   = mem_idx({15'd0, r_sp});
                        n_sp    = r_sp + 17'd4;
                        n_state = S_B;
                    end
                    OP_LI: n_acc = rdata;
                    OP_LC: n_acc = byte_sel;
                    OP_SI: begin
                        we    = 1'b1;
                        waddr = mem_idx(rdata);
                    end
                    OP_SC: begin
                        n_tmp   = rdata;
                        raddr   = mem_idx(rdata);
                        n_state = S_B;
                    end
                    OP_DIV, OP_MOD: begin
                        if (r_acc == 32'd0) begin
                            n_status = ST_DIVZ;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    default: n_acc = alu_y;
                endcase
            end

            // Second step
            S_B: begin
                n_state = S_OUT;
                case (r_op)
                    OP_CALL: begin
                        raddr   = mem_idx({16'd0, r_pc});
                        n_op    = OP_JMP;
                        n_state = S_A;
                    end
                    OP_LEV: n_pc = rdata[15:0];
                    default: begin
                        // byte store merge
                        we    = 1'b1;
                        waddr = mem_idx(r_tmp);
                        wdata = merged;
                        n_acc = sext8(r_acc[7:0]);
                    end
                endcase
            end

            S_DIV: begin
                if (div_done) begin
                    n_acc   = div_y;
                    n_state = S_OUT;
                end
            end

            S_RD: begin
                n_res   = rdata;
                n_state = S_OUT;
            end

            S_OUT: n_state = S_IDLE;

            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= 16'd0;
            r_acc   <= 32'd0;
            r_sp    <= 17'h10000;
            r_bp    <= 17'h10000;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_sp    <= n_sp;
            r_bp    <= n_bp;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_tmp    <= n_tmp;
        r_status <= n_status;
        r_res    <= n_res;
    end

    // Result
    assign busy              = (r_state != S_IDLE);
    assign o_done            = (r_state == S_OUT);
    assign o_status          = r_status;
    assign o_result_value    = r_res;
    assign o_program_counter = r_pc;
    assign o_accumulator     = r_acc;
    assign o_stack_pointer   = r_sp;
    assign o_frame_pointer   = r_bp;

endmodule

@@ src/svm_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// svm_ram: simple dual-port word memory
// One write port and one read port; read data registered.
// ============================================================================
module svm_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/svm_alu.sv @@
`timescale 1ns / 1ps
// ============================================================================
// svm_alu: shared arithmetic, logic, compare and shift unit
// Computes a op b for the two-operand opcodes other than divide and modulo.
// ============================================================================
module svm_alu import svm_pkg::*; (
    input  logic [5:0]  i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic big_shift;
    logic lt;

    assign big_shift = |i_b[31:5];
    assign lt        = $signed(i_a) < $signed(i_b);

    // Select the operation
    always_comb begin
        case (i_op)
            OP_OR:  o_y = i_a | i_b;
            OP_XOR: o_y = i_a ^ i_b;
            OP_AND: o_y = i_a & i_b;
            OP_EQ:  o_y = {31'd0, i_a == i_b};
            OP_NE:  o_y = {31'd0, i_a != i_b};
            OP_LT:  o_y = {31'd0, lt};
            OP_GT:  o_y = {31'd0, !lt && (i_a != i_b)};
            OP_LE:  o_y = {31'd0, lt || (i_a == i_b)};
            OP_GE:  o_y = {31'd0, !lt};
            OP_SHL: o_y = big_shift ? 32'd0 : (i_a << i_b[4:0]);
            OP_SHR: o_y = big_shift ? {32{i_a[31]}}
                                    : 32'($signed(i_a) >>> i_b[4:0]);
            OP_ADD: o_y = i_a + i_b;
            OP_SUB: o_y = i_a - i_b;
            OP_MUL: o_y = 32'(i_a * i_b);
            default: o_y = 32'd0;
        endcase
    end

endmodule

@@ src/svm_div.sv @@
`timescale 1ns / 1ps
// ============================================================================
// svm_div: iterative signed divider
// Restoring division, one quotient bit per cycle; gives quotient or remainder.
// ============================================================================
module svm_div import svm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_mod,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_y
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic        r_neg_q;
    logic        r_neg_r;
    logic        r_mod;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_div};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load magnitudes, then shift in one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= 32'd0;
            r_quo   <= i_a[31] ? (32'd0 - i_a) : i_a;
            r_div   <= i_b[31] ? (32'd0 - i_b) : i_b;
            r_neg_q <= i_a[31] ^ i_b[31];
            r_neg_r <= i_a[31];
            r_mod   <= i_mod;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // Apply signs
    assign o_y = r_mod ? (r_neg_r ? (32'd0 - r_rem) : r_rem)
                       : (r_neg_q ? (32'd0 - r_quo) : r_quo);

endmodule

@@ tb/sv/stack_vm_instruction_step_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stack_vm_instruction_step_tb: self-checking bench for the stack machine
// Drives memory, start and instruction requests, predicts every result with
// an in-bench machine model, and checks each strobed result field by field.
// ============================================================================
module stack_vm_instruction_step_tb import svm_pkg::*;;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 1650;
    localparam int DRAIN_CYCLES   = 48;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] value;
        logic [15:0] pc;
        logic [31:0] acc;
        logic [16:0] sp;
        logic [16:0] bp;
    } t_vm_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_kind = '0;
    logic [15:0]        i_address = '0;
    logic signed [31:0] i_write_data = '0;
    logic               o_done;
    logic [2:0]         o_status;
    logic signed [31:0] o_result_value;
    logic [15:0]        o_program_counter;
    logic signed [31:0] o_accumulator;
    logic [16:0]        o_stack_pointer;
    logic [16:0]        o_frame_pointer;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    stack_vm_instruction_step dut (.*);

    always #6 i_clk = ~i_clk;

    // Machine model state
    logic [31:0] vm_mem [MEM_WORDS];
    bit          vm_written [MEM_WORDS];
    logic [15:0] written_addrs [$];
    logic [15:0] pc_m = '0;
    logic [31:0] acc_m = '0;
    logic [16:0] sp_m = 17'd65536;
    logic [16:0] bp_m = 17'd65536;
    bit          halted_m = 1'b0;
    logic [15:0] start_cfg = '0;
    logic [16:0] stack_cfg = 17'd65536;

    t_vm_result expected_q [$];
    int         errors = 0;
    int         items_sent = 0;
    int         quiet_cycles = 0;
    bit         no_idle = 1'b0;

    // ------------------------------------------------------------------
    // Machine model
    // ------------------------------------------------------------------
    function automatic logic [31:0] mem_load(input logic [31:0] addr);
        return vm_mem[addr[IDX_W+1:2]];
    endfunction

    function automatic void mem_store(input logic [31:0] addr, input logic [31:0] v);
        if (!vm_written[addr[IDX_W+1:2]]) begin
            vm_written[addr[IDX_W+1:2]] = 1'b1;
            written_addrs.push_back(addr[15:0]);
        end
        vm_mem[addr[IDX_W+1:2]] = v;
    endfunction

    function automatic logic [31:0] fetch_word();
        logic [31:0] w;
        w = mem_load({16'b0, pc_m});
        pc_m = pc_m + 16'd4;
        return w;
    endfunction

    function automatic logic [31:0] pop_word();
        logic [31:0] w;
        w = mem_load({15'b0, sp_m});
        sp_m = sp_m + 17'd4;
        return w;
    endfunction

    function automatic void push_word(input logic [31:0] v);
        sp_m = sp_m - 17'd4;
        mem_store({15'b0, sp_m}, v);
    endfunction

    function automatic logic [31:0] sext_byte(input logic [31:0] b);
        return {{24{b[7]}}, b[7:0]};
    endfunction

    function automatic logic [2:0] run_instruction(output logic [31:0] exit_code);
        logic [31:0]        op, imm, a, w, t;
        logic signed [31:0] sa;
        int                 sh;
        exit_code = '0;
        if (halted_m) begin
            exit_code = mem_load({15'b0, sp_m});
            return ST_EXIT;
        end
        op = fetch_word();
        case (op)
            OP_IMM: acc_m = fetch_word();
            OP_LEA: begin
                imm = fetch_word();
                acc_m = {15'b0, bp_m} + (imm << 2);
            end
            OP_JMP: begin
                t = mem_load({16'b0, pc_m});
                pc_m = t[15:0];
            end
            OP_JZ: begin
                t = mem_load({16'b0, pc_m});
                pc_m = (acc_m != 0) ? pc_m + 16'd4 : t[15:0];
            end
            OP_JNZ: begin
                t = mem_load({16'b0, pc_m});
                pc_m = (acc_m != 0) ? t[15:0] : pc_m + 16'd4;
            end
            OP_CALL: begin
                push_word({16'b0, pc_m + 16'd4});
                t = mem_load({16'b0, pc_m});
                pc_m = t[15:0];
            end
            OP_ENT: begin
                imm = fetch_word();
                push_word({15'b0, bp_m});
                bp_m = sp_m;
                t = {15'b0, sp_m} - (imm << 2);
                sp_m = t[16:0];
            end
            OP_ADJ: begin
                imm = fetch_word();
                t = {15'b0, sp_m} + (imm << 2);
                sp_m = t[16:0];
            end
            OP_LEV: begin
                sp_m = bp_m;
                t = pop_word();
                bp_m = t[16:0];
                t = pop_word();
                pc_m = t[15:0];
            end
            OP_LI: acc_m = mem_load(acc_m);
            OP_LC: acc_m = sext_byte(mem_load(acc_m) >> (acc_m[1:0] * 8));
            OP_SI: begin
                a = pop_word();
                mem_store(a, acc_m);
            end
            OP_SC: begin
                a = pop_word();
                sh = a[1:0] * 8;
                w = mem_load(a);
                w = (w & ~(32'hFF << sh)) | ({24'b0, acc_m[7:0]} << sh);
                mem_store(a, w);
                acc_m = sext_byte(acc_m);
            end
            OP_PUSH: push_word(acc_m);
            OP_EXIT: begin
                halted_m = 1'b1;
                exit_code = mem_load({15'b0, sp_m});
                return ST_EXIT;
            end
            default: begin
                if (op >= OP_OR && op <= OP_MOD) begin
                    a = pop_word();
                    case (op)
                        OP_OR:  acc_m = a | acc_m;
                        OP_XOR: acc_m = a ^ acc_m;
                        OP_AND: acc_m = a & acc_m;
                        OP_EQ:  acc_m = (a == acc_m) ? 32'd1 : 32'd0;
                        OP_NE:  acc_m = (a != acc_m) ? 32'd1 : 32'd0;
                        OP_LT:  acc_m = ($signed(a) < $signed(acc_m)) ? 32'd1 : 32'd0;
                        OP_GT:  acc_m = ($signed(a) > $signed(acc_m)) ? 32'd1 : 32'd0;
                        OP_LE:  acc_m = ($signed(a) <= $signed(acc_m)) ? 32'd1 : 32'd0;
                        OP_GE:  acc_m = ($signed(a) >= $signed(acc_m)) ? 32'd1 : 32'd0;
                        OP_SHL: acc_m = (acc_m >= 32) ? 32'd0 : a << acc_m[4:0];
                        OP_SHR: begin
                            // Arithmetic shift keeps the sign fill
                            sa = a;
                            if (acc_m >= 32) acc_m = {32{a[31]}};
                            else acc_m = sa >>> acc_m[4:0];
                        end
                        OP_ADD: acc_m = a + acc_m;
                        OP_SUB: acc_m = a - acc_m;
                        OP_MUL: acc_m = a * acc_m;
                        default: begin
                            if (acc_m == 0) return ST_DIVZ;
                            // Most negative over minus one wraps to itself; its remainder is zero
                            if (a == 32'h8000_0000 && acc_m == 32'hFFFF_FFFF)
                                acc_m = (op == OP_DIV) ? a : 32'd0;
                            else if (op == OP_DIV)
                                acc_m = $signed(a) / $signed(acc_m);
                            else
                                acc_m = $signed(a) % $signed(acc_m);
                        end
                    endcase
                    return ST_OK;
                end
                if (op >= OP_OPEN && op <= OP_MCMP) return ST_SYSC;
                return ST_BADOP;
            end
        endcase
        return ST_OK;
    endfunction

    function automatic t_vm_result predict_request(input logic [1:0] k,
                                                   input logic [15:0] a,
                                                   input logic [31:0] d);
        t_vm_result r;
        r.status = ST_OK;
        r.value = '0;
        case (k)
            KIND_WRITE: mem_store({16'b0, a}, d);
            KIND_READ:  r.value = mem_load({16'b0, a});
            KIND_START: begin
                pc_m = start_cfg;
                sp_m = stack_cfg;
                bp_m = stack_cfg;
                acc_m = '0;
                halted_m = 1'b0;
            end
            default: r.status = run_instruction(r.value);
        endcase
        r.pc = pc_m;
        r.acc = acc_m;
        r.sp = sp_m;
        r.bp = bp_m;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request and configuration drivers
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] k, input logic [15:0] a,
                                input logic [31:0] d);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind = k;
        i_address = a;
        i_write_data = d;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_q.push_back(predict_request(k, a, d));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold until every result is back, then let the block settle
    task automatic drain();
        start = 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data, input logic [31:0] exp_rd);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (!wr && prdata !== exp_rd) log_mismatch("prdata", prdata, exp_rd);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Reprogram both registers while idle, read them back, then start
    task automatic configure(input logic [15:0] sa, input logic [16:0] st);
        drain();
        apb_access(1'b1, {REG_START, 2'b00}, {16'b0, sa}, '0);
        start_cfg = sa;
        apb_access(1'b1, {REG_STACK, 2'b00}, {15'b0, st}, '0);
        stack_cfg = st;
        apb_access(1'b0, {REG_START, 2'b00}, '0, {16'b0, start_cfg});
        apb_access(1'b0, {REG_STACK, 2'b00}, '0, {15'b0, stack_cfg});
        send_request(KIND_START, 16'($urandom), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_opcode();
        logic [31:0] w;
        case ($urandom_range(0, 15))
            12, 13: return $urandom_range(32'(OP_OPEN), 32'(OP_MCMP));
            14: return 32'(OP_EXIT);
            15: begin
                w = $urandom;
                if (w <= OP_EXIT) w = w + OP_EXIT + 1;
                return w;
            end
            default: return $urandom_range(32'(OP_LEA), 32'(OP_MOD));
        endcase
    endfunction

    // Give a word a value before the block reads it
    task automatic ensure_word(input logic [31:0] addr);
        if (!vm_written[addr[IDX_W+1:2]]) send_request(KIND_WRITE, addr[15:0], pick_value());
    endtask

    // Place one instruction at pc, back every word it reads, then execute it (when halted, only back the stack word)
    task automatic exec_op(input logic [31:0] opw, input logic [31:0] operand);
        if (!halted_m) begin
            send_request(KIND_WRITE, pc_m, opw);
            if (opw <= OP_ADJ) send_request(KIND_WRITE, pc_m + 16'd4, operand);
            if ((opw >= OP_OR && opw <= OP_MOD) || opw == OP_SI || opw == OP_SC ||
                opw == OP_EXIT)
                ensure_word({15'b0, sp_m});
            if (opw == OP_SC) ensure_word(mem_load({15'b0, sp_m}));
            if (opw == OP_LEV) begin
                ensure_word({15'b0, bp_m});
                ensure_word({15'b0, bp_m + 17'd4});
            end
            if (opw == OP_LI || opw == OP_LC) ensure_word(acc_m);
        end else begin
            ensure_word({15'b0, sp_m});
        end
        send_request(KIND_EXEC, 16'($urandom), $urandom);
    endtask

    task automatic binary_op(input logic [31:0] lhs, input logic [31:0] rhs,
                             input logic [31:0] opw);
        exec_op(32'(OP_IMM), lhs);
        exec_op(32'(OP_PUSH), '0);
        exec_op(32'(OP_IMM), rhs);
        exec_op(opw, '0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_memory_access();
        send_request(KIND_WRITE, 16'h0000, 32'h8000_0000);
        send_request(KIND_WRITE, 16'hFFFF, 32'h7FFF_FFFF);
        send_request(KIND_READ, 16'h0003, '0);
        send_request(KIND_READ, 16'hFFFC, 32'hFFFF_FFFF);
        send_request(KIND_WRITE, 16'h8000, 32'hFFFF_FFFF);
        send_request(KIND_READ, 16'h8001, '0);
    endtask

    task automatic test_special_cases();
        configure(16'h0100, 17'd65536);
        binary_op(32'h8000_0000, 32'hFFFF_FFFF, 32'(OP_DIV));
        binary_op(32'h8000_0000, 32'hFFFF_FFFF, 32'(OP_MOD));
        binary_op(32'd7, 32'd0, 32'(OP_DIV));
        binary_op(32'h8000_0000, 32'd33, 32'(OP_SHR));
        binary_op(32'hFFFF_FFFF, 32'd32, 32'(OP_SHL));
        // Byte store then signed byte load
        exec_op(32'(OP_IMM), 32'h0000_4001);
        exec_op(32'(OP_PUSH), '0);
        exec_op(32'(OP_IMM), 32'h0000_01F0);
        exec_op(32'(OP_SC), '0);
        exec_op(32'(OP_IMM), 32'h0000_4001);
        exec_op(32'(OP_LC), '0);
        exec_op(32'(OP_OPEN), '0);
        exec_op(32'hFFFF_FFFF, '0);
        exec_op(32'(OP_EXIT), '0);
        exec_op(32'(OP_IMM), 32'd5);
        send_request(KIND_START, '0, '0);
    endtask

    task automatic test_random_programs(input int item_limit);
        logic [31:0] opw;
        while (items_sent < item_limit) begin
            case ($urandom_range(0, 19))
                0: send_request(KIND_WRITE, 16'($urandom), $urandom);
                1: send_request(KIND_READ,
                                written_addrs[$urandom_range(0, written_addrs.size() - 1)]
                                ^ 16'($urandom_range(0, 3)), $urandom);
                2: send_request(KIND_START, 16'($urandom), $urandom);
                3, 4, 5, 6, 7: binary_op(pick_value(), pick_value(),
                                         $urandom_range(OP_OR, OP_MOD));
                default: begin
                    if (halted_m && $urandom_range(0, 2) == 0) begin
                        send_request(KIND_START, 16'($urandom), $urandom);
                    end else begin
                        opw = pick_opcode();
                        exec_op(opw, pick_value());
                    end
                end
            endcase
            no_idle = ($urandom_range(0, 15) == 0) ? ~no_idle : no_idle;
        end
    endtask

    task automatic test_config_sweep();
        configure(16'hFFFF, 17'd0);
        test_random_programs(items_sent + 300);
        configure(16'h0000, 17'd65536);
        test_random_programs(items_sent + 300);
        configure(16'($urandom), 17'($urandom_range(0, 65536)));
        test_random_programs(items_sent + 300);
        configure(16'hFFFC, 17'd4);
        test_random_programs(ITEM_TARGET);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] exp_v);
        $display("mismatch %s: got %08h expected %08h at %0t", what, got, exp_v, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_vm_result e;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                log_mismatch("unexpected result", {29'd0, o_status}, '0);
            end else begin
                e = expected_q.pop_front();
                if (o_status !== e.status)
                    log_mismatch("status", {29'd0, o_status}, {29'd0, e.status});
                if (o_result_value !== e.value) log_mismatch("value", o_result_value, e.value);
                if (o_program_counter !== e.pc)
                    log_mismatch("pc", {16'd0, o_program_counter}, {16'd0, e.pc});
                if (o_accumulator !== e.acc) log_mismatch("acc", o_accumulator, e.acc);
                if (o_stack_pointer !== e.sp)
                    log_mismatch("sp", {15'd0, o_stack_pointer}, {15'd0, e.sp});
                if (o_frame_pointer !== e.bp)
                    log_mismatch("bp", {15'd0, o_frame_pointer}, {15'd0, e.bp});
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("stack_vm_instruction_step_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_memory_access();
        test_special_cases();
        test_config_sweep();
        drain();
        if (errors == 0 && expected_q.size() == 0) begin
            $display("stack_vm_instruction_step_tb passed");
        end else begin
            $display("stack_vm_instruction_step_tb failed");
        end
        $finish;
    end

endmodule
